FILE: src/hybrid_branch_predictor_macros.svh
// Assertion macros shared by the hybrid branch predictor RTL.
`ifndef HYBRID_BRANCH_PREDICTOR_MACROS_SVH
`define HYBRID_BRANCH_PREDICTOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define HBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define HBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/hbp_pkg.sv
// Types, constants and helper functions of the hybrid branch predictor.
`timescale 1ns / 1ps
package hbp_pkg;

    localparam int BIM_BITS  = 12;
    localparam int GSH_BITS  = 12;
    localparam int CHO_BITS  = 12;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 4;
    localparam int BITCNT_W  = 5;
    localparam int CTR_W     = 2;
    localparam int PADDR_W   = 5;
    localparam int REGIDX_W  = 3;
    localparam int CLR_BITS  = (BIM_BITS > GSH_BITS) ?
                               ((BIM_BITS > CHO_BITS) ? BIM_BITS : CHO_BITS) :
                               ((GSH_BITS > CHO_BITS) ? GSH_BITS : CHO_BITS);

    // Predictor kinds
    localparam logic [1:0] MODE_BIM = 2'd0;
    localparam logic [1:0] MODE_GSH = 2'd1;
    localparam logic [1:0] MODE_HYB = 2'd2;

    // Register indexes
    localparam logic [REGIDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_BIM  = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_GSH  = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_HIST = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_CHO  = 3'd4;

    // Counter values
    localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;
    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_WEAK_BIM   = 2'd1;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CFG_W-1:0] bim_bits;
        logic [CFG_W-1:0] gsh_bits;
        logic [CFG_W-1:0] hist_bits;
        logic [CFG_W-1:0] cho_bits;
    } t_cfg;

    typedef struct packed {
        logic [BIM_BITS-1:0] bi;
        logic [GSH_BITS-1:0] gi;
        logic [CHO_BITS-1:0] ci;
    } t_idx;

    typedef struct packed {
        logic             pred;
        logic             miss;
        logic             use_g;
        logic             bim_we;
        logic             gsh_we;
        logic             cho_we;
        logic [CTR_W-1:0] bim_val;
        logic [CTR_W-1:0] gsh_val;
        logic [CTR_W-1:0] cho_val;
    } t_upd;

    // Clamp a configured width to 1..maxb
    function automatic logic [BITCNT_W-1:0] clamp_bits(input logic [CFG_W-1:0] v,
                                                       input logic [BITCNT_W-1:0] maxb);
        logic [BITCNT_W-1:0] ve;
        ve = BITCNT_W'(v);
        if (ve == '0) begin
            return BITCNT_W'(1);
        end else if (ve > maxb) begin
            return maxb;
        end
        return ve;
    endfunction

    // Step a 2-bit saturating counter toward the outcome
    function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c,
                                                   input logic taken);
        if (taken) begin
            return (c == CTR_MAX) ? CTR_MAX : c + 1'b1;
        end
        return (c == '0) ? '0 : c - 1'b1;
    endfunction

endpackage

FILE: src/hbp_ram.sv
// Counter table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module hbp_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 2
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // Write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/hbp_index.sv
// Table index generation and global history register.
`timescale 1ns / 1ps
module hbp_index (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hbp_pkg::t_cfg i_cfg,
    input  logic [31:0]   i_addr,
    input  logic          i_taken,
    input  logic          i_accept,
    output hbp_pkg::t_idx o_idx
);
    import hbp_pkg::*;

    logic [GSH_BITS-1:0] r_hist;
    logic [GSH_BITS-1:0] n_hist;
    logic [BITCNT_W-1:0] mb, mg, kc, nh;
    logic [GSH_BITS-1:0] hmask, gmask, hist;
    logic [BIM_BITS-1:0] bmask;
    logic [CHO_BITS-1:0] cmask;
    logic [29:0]         word;

    // Clamp widths, build masks and indices
    always_comb begin
        mb = clamp_bits(i_cfg.bim_bits, BITCNT_W'(BIM_BITS));
        mg = clamp_bits(i_cfg.gsh_bits, BITCNT_W'(GSH_BITS));
        kc = clamp_bits(i_cfg.cho_bits, BITCNT_W'(CHO_BITS));
        nh = clamp_bits(i_cfg.hist_bits, BITCNT_W'(GSH_BITS));
        if (nh > mg) begin
            nh = mg;
        end
        bmask = BIM_BITS'((32'd1 << mb) - 32'd1);
        gmask = GSH_BITS'((32'd1 << mg) - 32'd1);
        cmask = CHO_BITS'((32'd1 << kc) - 32'd1);
        hmask = GSH_BITS'((32'd1 << nh) - 32'd1);
        hist  = r_hist & hmask;
        word  = i_addr[31:2];
        o_idx.bi = word[BIM_BITS-1:0] & bmask;
        o_idx.gi = (word[GSH_BITS-1:0] ^ (hist << (mg - nh))) & gmask;
        o_idx.ci = word[CHO_BITS-1:0] & cmask;
        // Shift the outcome in at the top of the active history
        n_hist = hist >> 1;
        if (i_taken) begin
            n_hist = n_hist | (GSH_BITS'(1) << (nh - 1'b1));
        end
        n_hist = n_hist & hmask;
    end

    // Advance history on every accepted branch outside bimodal mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_accept && (i_cfg.mode != MODE_BIM)) begin
            r_hist <= n_hist;
        end
    end

endmodule

FILE: src/hbp_decide.sv
// Prediction, chooser decision and counter training for one branch.
`timescale 1ns / 1ps
module hbp_decide (
    input  logic                      i_taken,
    input  logic [1:0]                i_mode,
    input  logic [hbp_pkg::CTR_W-1:0] i_bim_ctr,
    input  logic [hbp_pkg::CTR_W-1:0] i_gsh_ctr,
    input  logic [hbp_pkg::CTR_W-1:0] i_cho_ctr,
    output hbp_pkg::t_upd             o_upd
);
    import hbp_pkg::*;

    logic bim_pred, gsh_pred, g_ok, b_ok;

    // Pick the predictor and train the counters
    always_comb begin
        bim_pred = (i_bim_ctr >= CTR_WEAK_TAKEN);
        gsh_pred = (i_gsh_ctr >= CTR_WEAK_TAKEN);
        g_ok     = (gsh_pred == i_taken);
        b_ok     = (bim_pred == i_taken);
        o_upd         = '0;
        o_upd.bim_val = ctr_train(i_bim_ctr, i_taken);
        o_upd.gsh_val = ctr_train(i_gsh_ctr, i_taken);
        o_upd.cho_val = ctr_train(i_cho_ctr, g_ok);
        case (i_mode)
            MODE_BIM: begin
                o_upd.pred   = bim_pred;
                o_upd.bim_we = 1'b1;
            end
            MODE_GSH: begin
                o_upd.pred   = gsh_pred;
                o_upd.use_g  = 1'b1;
                o_upd.gsh_we = 1'b1;
            end
            default: begin
                // Hybrid; the spare code acts the same
                o_upd.use_g  = (i_cho_ctr >= CTR_WEAK_TAKEN);
                o_upd.pred   = o_upd.use_g ? gsh_pred : bim_pred;
                o_upd.cho_we = g_ok ^ b_ok;
                o_upd.gsh_we = o_upd.use_g;
                o_upd.bim_we = !o_upd.use_g;
            end
        endcase
        o_upd.miss = (o_upd.pred != i_taken);
    end

endmodule

FILE: src/hybrid_branch_predictor.sv
// Pipeline: an accepted branch is held in stage 1 while its counters are read, then registered as
// the result. Throughput: one branch per cycle unless o_stall or i_stall holds the flow; each table
// does one read at accept and one read-modify-write later, with the previous write forwarded on a
// same-entry hit. Reset: synchronous, active low; clears history, totals and config to defaults, then
// runs a table initialization pass over all 4096 entries with o_stall high.
`timescale 1ns / 1ps
`include "hybrid_branch_predictor_macros.svh"
module hybrid_branch_predictor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [31:0]                 i_branch_address,
    input  logic                        i_branch_taken,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_predicted_taken,
    output logic                        o_mispredicted,
    output logic                        o_used_gshare,
    output logic [31:0]                 o_prediction_total,
    output logic [31:0]                 o_misprediction_total,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hbp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import hbp_pkg::*;

    logic [1:0]          r_mode;
    logic [CFG_W-1:0]    r_bim_bits, r_gsh_bits, r_hist_bits, r_cho_bits;
    t_cfg                cfg;
    logic [REGIDX_W-1:0] reg_idx;

    logic                r_clr_busy;
    logic [CLR_BITS-1:0] r_clr_idx;

    logic                acc, s1_adv;
    t_idx                idx;
    logic                r_s1_valid;
    t_idx                r_s1_idx;
    logic                r_s1_taken;
    logic                r_bim_fwd, r_gsh_fwd, r_cho_fwd;
    logic [CTR_W-1:0]    r_bim_fwd_val, r_gsh_fwd_val, r_cho_fwd_val;
    logic [CTR_W-1:0]    bim_q, gsh_q, cho_q;
    logic [CTR_W-1:0]    bim_ctr, gsh_ctr, cho_ctr;
    t_upd                upd;

    logic                bim_we, gsh_we, cho_we;
    logic [BIM_BITS-1:0] bim_waddr;
    logic [GSH_BITS-1:0] gsh_waddr;
    logic [CHO_BITS-1:0] cho_waddr;
    logic [CTR_W-1:0]    bim_wdata, gsh_wdata, cho_wdata;

    logic                r_out_valid;
    logic                r_out_pred, r_out_miss, r_out_use_g;
    logic [COUNT_W-1:0]  r_pred_cnt, r_miss_cnt;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_BIM;
            r_bim_bits  <= CFG_W'(BIM_BITS);
            r_gsh_bits  <= CFG_W'(GSH_BITS);
            r_hist_bits <= CFG_W'(8);
            r_cho_bits  <= CFG_W'(CHO_BITS);
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_MODE: r_mode      <= pwdata[1:0];
                REG_BIM:  r_bim_bits  <= pwdata[CFG_W-1:0];
                REG_GSH:  r_gsh_bits  <= pwdata[CFG_W-1:0];
                REG_HIST: r_hist_bits <= pwdata[CFG_W-1:0];
                REG_CHO:  r_cho_bits  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE: prdata = 32'(r_mode);
            REG_BIM:  prdata = 32'(r_bim_bits);
            REG_GSH:  prdata = 32'(r_gsh_bits);
            REG_HIST: prdata = 32'(r_hist_bits);
            REG_CHO:  prdata = 32'(r_cho_bits);
            default:  prdata = '0;
        endcase
    end

    assign cfg = '{mode: r_mode, bim_bits: r_bim_bits, gsh_bits: r_gsh_bits,
                   hist_bits: r_hist_bits, cho_bits: r_cho_bits};

    // Table initialization pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Handshake
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_clr_busy || (r_s1_valid && !s1_adv);
    assign acc     = i_valid && !o_stall;

    hbp_index u_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_addr   (i_branch_address),
        .i_taken  (i_branch_taken),
        .i_accept (acc),
        .o_idx    (idx)
    );

    // Table write ports: init pass or training
    always_comb begin
        bim_we    = r_clr_busy || (s1_adv && upd.bim_we);
        gsh_we    = r_clr_busy || (s1_adv && upd.gsh_we);
        cho_we    = r_clr_busy || (s1_adv && upd.cho_we);
        bim_waddr = r_clr_busy ? r_clr_idx[BIM_BITS-1:0] : r_s1_idx.bi;
        gsh_waddr = r_clr_busy ? r_clr_idx[GSH_BITS-1:0] : r_s1_idx.gi;
        cho_waddr = r_clr_busy ? r_clr_idx[CHO_BITS-1:0] : r_s1_idx.ci;
        bim_wdata = r_clr_busy ? CTR_WEAK_TAKEN : upd.bim_val;
        gsh_wdata = r_clr_busy ? CTR_WEAK_TAKEN : upd.gsh_val;
        cho_wdata = r_clr_busy ? CTR_WEAK_BIM   : upd.cho_val;
    end

    hbp_ram #(.ADDR_W(BIM_BITS), .DATA_W(CTR_W)) u_bim_ram (
        .i_clk   (i_clk),
        .i_we    (bim_we),
        .i_waddr (bim_waddr),
        .i_wdata (bim_wdata),
        .i_re    (acc),
        .i_raddr (idx.bi),
        .o_rdata (bim_q)
    );

    hbp_ram #(.ADDR_W(GSH_BITS), .DATA_W(CTR_W)) u_gsh_ram (
        .i_clk   (i_clk),
        .i_we    (gsh_we),
        .i_waddr (gsh_waddr),
        .i_wdata (gsh_wdata),
        .i_re    (acc),
        .i_raddr (idx.gi),
        .o_rdata (gsh_q)
    );

    hbp_ram #(.ADDR_W(CHO_BITS), .DATA_W(CTR_W)) u_cho_ram (
        .i_clk   (i_clk),
        .i_we    (cho_we),
        .i_waddr (cho_waddr),
        .i_wdata (cho_wdata),
        .i_re    (acc),
        .i_raddr (idx.ci),
        .o_rdata (cho_q)
    );

    // Stage 1: hold the beat while its counters are read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Capture indices and forward a write that lands on the entry being read
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_idx      <= idx;
            r_s1_taken    <= i_branch_taken;
            r_bim_fwd     <= s1_adv && upd.bim_we && (r_s1_idx.bi == idx.bi);
            r_gsh_fwd     <= s1_adv && upd.gsh_we && (r_s1_idx.gi == idx.gi);
            r_cho_fwd     <= s1_adv && upd.cho_we && (r_s1_idx.ci == idx.ci);
            r_bim_fwd_val <= upd.bim_val;
            r_gsh_fwd_val <= upd.gsh_val;
            r_cho_fwd_val <= upd.cho_val;
        end
    end

    assign bim_ctr = r_bim_fwd ? r_bim_fwd_val : bim_q;
    assign gsh_ctr = r_gsh_fwd ? r_gsh_fwd_val : gsh_q;
    assign cho_ctr = r_cho_fwd ? r_cho_fwd_val : cho_q;

    hbp_decide u_decide (
        .i_taken   (r_s1_taken),
        .i_mode    (r_mode),
        .i_bim_ctr (bim_ctr),
        .i_gsh_ctr (gsh_ctr),
        .i_cho_ctr (cho_ctr),
        .o_upd     (upd)
    );

    // Result register and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pred_cnt  <= '0;
            r_miss_cnt  <= '0;
        end else begin
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                if (r_pred_cnt != '1) begin
                    r_pred_cnt <= r_pred_cnt + 1'b1;
                end
                if (upd.miss && (r_miss_cnt != '1)) begin
                    r_miss_cnt <= r_miss_cnt + 1'b1;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pred  <= upd.pred;
            r_out_miss  <= upd.miss;
            r_out_use_g <= upd.use_g;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_predicted_taken     = r_out_pred;
    assign o_mispredicted        = r_out_miss;
    assign o_used_gshare         = r_out_use_g;
    assign o_prediction_total    = 32'(r_pred_cnt);
    assign o_misprediction_total = 32'(r_miss_cnt);

    // Checks
    `HBP_ASSERT_NOW(a_no_accept_in_init, r_clr_busy, !acc, "branch accepted during init")
    `HBP_ASSERT_NOW(a_miss_le_total, 1'b1, r_miss_cnt <= r_pred_cnt, "miss total above total")
    `HBP_ASSERT_NEXT(a_total_step, s1_adv && (r_pred_cnt != '1), r_pred_cnt == $past(r_pred_cnt) + 1'b1, "total did not step")
    `HBP_ASSERT_NOW(a_bim_mode_no_gshare, r_s1_valid && (r_mode == MODE_BIM), !upd.gsh_we && !upd.use_g, "gshare touched in bimodal mode")

endmodule
